// File: hw/rtl/hdlc_frame_receiver_defines.svh
// Assertion macros for the HDLC frame receiver.
// Used by files that check their own logic; no other dependencies.
`ifndef HDLC_FRAME_RECEIVER_DEFINES_SVH
`define HDLC_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that cond holds at every edge out of reset.
`define HDLC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that cons holds in the same cycle whenever ante holds.
`define HDLC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante holds.
`define HDLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HDLC_ASSERT_ALWAYS(lbl, cond, msg)
`define HDLC_ASSERT_IMPL(lbl, ante, cons, msg)
`define HDLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/hdlc_rx_pkg.sv
// Shared types, constants and the FCS-16 step for the HDLC frame receiver.
// No dependencies.
package hdlc_rx_pkg;

    // Raw wire codes
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_FLAG    = 8'h5E;
    localparam logic [7:0] ESC_ESC     = 8'h5D;

    // Header constants
    localparam logic [7:0] HDR_ADDR_VAL = 8'hFF;
    localparam logic [7:0] HDR_CTRL_VAL = 8'h03;
    localparam logic [7:0] TYPE_TX_ERR  = 8'h40;
    localparam logic [7:0] TYPE_APP_ERR = 8'h20;

    // Header byte positions
    localparam logic [7:0] POS_ADDR     = 8'd0;
    localparam logic [7:0] POS_CTRL     = 8'd1;
    localparam logic [7:0] POS_SRC_NET  = 8'd2;
    localparam logic [7:0] POS_SRC_ADR  = 8'd3;
    localparam logic [7:0] POS_DST_NET  = 8'd4;
    localparam logic [7:0] POS_DST_ADR  = 8'd5;
    localparam logic [7:0] POS_SIZE     = 8'd6;
    localparam logic [7:0] FCS_LEN      = 8'd2;

    // FCS-16
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_GOOD = 16'hF0B8;

    // Configuration register indexes
    localparam logic CFG_HOST_NETWORK = 1'b0;
    localparam logic CFG_HOST_ADDRESS = 1'b1;

    // Token queue geometry
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_FCS     = 3'd3,
        PH_END     = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TX_ERR   = 3'd1,
        ST_APP_ERR  = 3'd2,
        ST_NO_END   = 3'd3,
        ST_FCS_ERR  = 3'd4,
        ST_TRUNC    = 3'd5
    } status_t;

    // Classified wire byte
    typedef struct packed {
        logic       delim;
        logic       escape;
        logic       last;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [7:0] network;
        logic [7:0] address;
    } host_cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        status_t    status;
        logic [7:0] origin_network;
        logic [7:0] origin_address;
        logic [7:0] frame_type;
        logic [7:0] payload_size;
    } result_t;

    // One byte through the reflected CRC-16, LSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/hdlc_rx_front.sv
// Front end: accepts raw wire bytes and classifies them into tokens.
// Depends on hdlc_rx_pkg.
module hdlc_rx_front (
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [7:0]           wire_byte,
    input  logic                 burst_end,
    input  hdlc_rx_pkg::q_stat_t q_stat,
    output logic                 push,
    output hdlc_rx_pkg::token_t  push_token
);

    // Hold the wire while the queue has no room
    assign rx_stall = q_stat.full;
    assign push     = rx_valid && !q_stat.full;

    // Mark raw delimiter and escape codes
    always_comb
    begin
        push_token.delim  = (wire_byte == hdlc_rx_pkg::FLAG_BYTE);
        push_token.escape = (wire_byte == hdlc_rx_pkg::ESC_BYTE);
        push_token.last   = burst_end;
        push_token.data   = wire_byte;
    end

endmodule

// File: hw/rtl/hdlc_rx_queue.sv
// Short token queue between the front end and the frame engine.
// Depends on hdlc_rx_pkg.
module hdlc_rx_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hdlc_rx_pkg::token_t  push_token,
    input  logic                 pop,
    output hdlc_rx_pkg::token_t  pop_token,
    output hdlc_rx_pkg::q_stat_t q_stat
);

    hdlc_rx_pkg::token_t             mem [hdlc_rx_pkg::QDepth];
    logic [hdlc_rx_pkg::QPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hdlc_rx_pkg::QPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [hdlc_rx_pkg::QPtrW:0]     count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store tokens
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    assign pop_token    = mem[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == (hdlc_rx_pkg::QPtrW+1)'(hdlc_rx_pkg::QDepth));

endmodule

// File: hw/rtl/hdlc_rx_back.sv
// Frame engine: unstuffing, header check, FCS-16 and result register.
// Depends on hdlc_rx_pkg; consumes tokens from hdlc_rx_queue.
module hdlc_rx_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hdlc_rx_pkg::host_cfg_t host,
    input  hdlc_rx_pkg::q_stat_t  q_stat,
    input  hdlc_rx_pkg::token_t   tok,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output hdlc_rx_pkg::result_t  res
);

    hdlc_rx_pkg::phase_t phase_reg, phase_next;
    logic [7:0]          count_reg, count_next;
    logic                esc_reg, esc_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          src_net_reg, src_net_next;
    logic [7:0]          src_adr_reg, src_adr_next;
    logic [7:0]          type_reg, type_next;
    logic [7:0]          size_reg, size_next;

    logic                res_valid_reg, res_valid_next;
    hdlc_rx_pkg::result_t res_reg;

    logic                fb_en;
    logic [7:0]          fb_val;
    logic [7:0]          cnt_inc;
    logic                hit;
    logic                hit_kind;
    logic [7:0]          hit_data;
    hdlc_rx_pkg::status_t hit_status;

    assign cnt_inc = count_reg + 8'd1;

    // Step the frame state for one token
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        esc_next     = esc_reg;
        crc_next     = crc_reg;
        src_net_next = src_net_reg;
        src_adr_next = src_adr_reg;
        type_next    = type_reg;
        size_next    = size_reg;
        fb_en        = 1'b0;
        fb_val       = tok.data;
        hit          = 1'b0;
        hit_kind     = 1'b0;
        hit_data     = 8'h00;
        hit_status   = hdlc_rx_pkg::ST_OK;

        case (phase_reg)
            hdlc_rx_pkg::PH_HUNT:
            begin
                if (tok.delim)
                begin
                    phase_next   = hdlc_rx_pkg::PH_HEADER;
                    count_next   = 8'd0;
                    esc_next     = 1'b0;
                    crc_next     = hdlc_rx_pkg::CRC_INIT;
                    src_net_next = 8'd0;
                    src_adr_next = 8'd0;
                    type_next    = 8'd0;
                    size_next    = 8'd0;
                end
            end
            hdlc_rx_pkg::PH_END:
            begin
                hit      = 1'b1;
                hit_kind = 1'b1;
                if (!tok.delim)
                begin
                    hit_status = hdlc_rx_pkg::ST_NO_END;
                end
                else if (crc_reg != hdlc_rx_pkg::CRC_GOOD)
                begin
                    hit_status = hdlc_rx_pkg::ST_FCS_ERR;
                end
                phase_next = hdlc_rx_pkg::PH_HUNT;
                esc_next   = 1'b0;
            end
            hdlc_rx_pkg::PH_HEADER, hdlc_rx_pkg::PH_PAYLOAD, hdlc_rx_pkg::PH_FCS:
            begin
                if (tok.delim)
                begin
                    // Delimiter mid-frame reopens; outside the header it also ends one
                    if (phase_reg != hdlc_rx_pkg::PH_HEADER)
                    begin
                        hit        = 1'b1;
                        hit_kind   = 1'b1;
                        hit_status = hdlc_rx_pkg::ST_NO_END;
                    end
                    phase_next   = hdlc_rx_pkg::PH_HEADER;
                    count_next   = 8'd0;
                    esc_next     = 1'b0;
                    crc_next     = hdlc_rx_pkg::CRC_INIT;
                    src_net_next = 8'd0;
                    src_adr_next = 8'd0;
                    type_next    = 8'd0;
                    size_next    = 8'd0;
                end
                else if (esc_reg)
                begin
                    // Undo a valid escape pair, drop any other
                    esc_next = 1'b0;
                    if (tok.data == hdlc_rx_pkg::ESC_FLAG)
                    begin
                        fb_en  = 1'b1;
                        fb_val = hdlc_rx_pkg::FLAG_BYTE;
                    end
                    else if (tok.data == hdlc_rx_pkg::ESC_ESC)
                    begin
                        fb_en  = 1'b1;
                        fb_val = hdlc_rx_pkg::ESC_BYTE;
                    end
                end
                else if (tok.escape)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    fb_en = 1'b1;
                end
            end
            default:
            begin
                phase_next = hdlc_rx_pkg::PH_HUNT;
                esc_next   = 1'b0;
            end
        endcase

        // Handle one unstuffed frame byte
        if (fb_en)
        begin
            crc_next = hdlc_rx_pkg::crc16_feed(crc_reg, fb_val);
            case (phase_reg)
                hdlc_rx_pkg::PH_HEADER:
                begin
                    count_next = cnt_inc;
                    case (count_reg)
                        hdlc_rx_pkg::POS_ADDR:
                        begin
                            if (fb_val != hdlc_rx_pkg::HDR_ADDR_VAL)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                            end
                        end
                        hdlc_rx_pkg::POS_CTRL:
                        begin
                            if (fb_val != hdlc_rx_pkg::HDR_CTRL_VAL)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                            end
                        end
                        hdlc_rx_pkg::POS_SRC_NET:
                        begin
                            src_net_next = fb_val;
                        end
                        hdlc_rx_pkg::POS_SRC_ADR:
                        begin
                            src_adr_next = fb_val;
                            // Drop frames that claim to come from this host
                            if (src_net_reg == host.network && fb_val == host.address)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                            end
                        end
                        hdlc_rx_pkg::POS_DST_NET:
                        begin
                            if (fb_val != host.network)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                            end
                        end
                        hdlc_rx_pkg::POS_DST_ADR:
                        begin
                            if (fb_val != host.address)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                            end
                        end
                        hdlc_rx_pkg::POS_SIZE:
                        begin
                            size_next = fb_val;
                        end
                        default:
                        begin
                            // Type byte: error bits end the frame at once
                            type_next = fb_val;
                            if ((fb_val & hdlc_rx_pkg::TYPE_TX_ERR) != 8'h00)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                                hit        = 1'b1;
                                hit_kind   = 1'b1;
                                hit_status = hdlc_rx_pkg::ST_TX_ERR;
                            end
                            else if ((fb_val & hdlc_rx_pkg::TYPE_APP_ERR) != 8'h00)
                            begin
                                phase_next = hdlc_rx_pkg::PH_HUNT;
                                esc_next   = 1'b0;
                                count_next = count_reg;
                                hit        = 1'b1;
                                hit_kind   = 1'b1;
                                hit_status = hdlc_rx_pkg::ST_APP_ERR;
                            end
                            else
                            begin
                                count_next = 8'd0;
                                phase_next = (size_reg == 8'd0) ? hdlc_rx_pkg::PH_FCS
                                                                : hdlc_rx_pkg::PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                hdlc_rx_pkg::PH_PAYLOAD:
                begin
                    count_next = cnt_inc;
                    if (cnt_inc == size_reg)
                    begin
                        count_next = 8'd0;
                        phase_next = hdlc_rx_pkg::PH_FCS;
                    end
                    hit      = 1'b1;
                    hit_kind = 1'b0;
                    hit_data = fb_val;
                end
                default:
                begin
                    count_next = cnt_inc;
                    if (cnt_inc >= hdlc_rx_pkg::FCS_LEN)
                    begin
                        count_next = 8'd0;
                        phase_next = hdlc_rx_pkg::PH_END;
                    end
                end
            endcase
        end

        // Burst end truncates any open frame unless a status already stands
        if (tok.last && phase_next != hdlc_rx_pkg::PH_HUNT)
        begin
            phase_next = hdlc_rx_pkg::PH_HUNT;
            esc_next   = 1'b0;
            if (!(hit && hit_kind))
            begin
                hit        = 1'b1;
                hit_kind   = 1'b1;
                hit_data   = 8'h00;
                hit_status = hdlc_rx_pkg::ST_TRUNC;
            end
        end
    end

    // Take a token when the result register is free or being drained
    always_comb
    begin
        pop            = q_stat.valid && (!res_valid_reg || !res_stall);
        res_valid_next = res_valid_reg && res_stall;
        if (pop && hit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hdlc_rx_pkg::PH_HUNT;
            count_reg     <= 8'd0;
            esc_reg       <= 1'b0;
            crc_reg       <= hdlc_rx_pkg::CRC_INIT;
            src_net_reg   <= 8'd0;
            src_adr_reg   <= 8'd0;
            type_reg      <= 8'd0;
            size_reg      <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                esc_reg     <= esc_next;
                crc_reg     <= crc_next;
                src_net_reg <= src_net_next;
                src_adr_reg <= src_adr_next;
                type_reg    <= type_next;
                size_reg    <= size_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop && hit)
        begin
            res_reg.kind           <= hit_kind;
            res_reg.data_byte      <= hit_data;
            res_reg.status         <= hit_status;
            res_reg.origin_network <= src_net_next;
            res_reg.origin_address <= src_adr_next;
            res_reg.frame_type     <= type_next;
            res_reg.payload_size   <= size_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/hdlc_frame_receiver.sv
// A wire byte accepted into the token queue is popped by the frame engine,
// which loads its result into the result register for transfer.
// Throughput: one wire byte per cycle unless the queue is full, set by the
// engine step (unstuff, header check, FCS-16 byte update); a four-token queue
// absorbs stalls on the result side. Reset is asynchronous and active low,
// clears all frame state and host registers at once; no clearing pass.
// Top level of the HDLC frame receiver; uses hdlc_rx_pkg, hdlc_rx_front,
// hdlc_rx_queue, hdlc_rx_back and hdlc_frame_receiver_defines.svh.
`include "hdlc_frame_receiver_defines.svh"

module hdlc_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    // Wire byte channel
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] wire_byte,
    input  logic       burst_end,
    // Result channel
    output logic       res_valid,
    input  logic       res_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic [2:0] status,
    output logic [7:0] origin_network,
    output logic [7:0] origin_address,
    output logic [7:0] frame_type,
    output logic [7:0] payload_size,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    hdlc_rx_pkg::host_cfg_t host_reg, host_next;
    hdlc_rx_pkg::q_stat_t   q_stat;
    hdlc_rx_pkg::token_t    push_token;
    hdlc_rx_pkg::token_t    pop_token;
    hdlc_rx_pkg::result_t   res;
    logic                   push;
    logic                   pop;
    logic                   status_ok;

    // Host registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        host_next = host_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                hdlc_rx_pkg::CFG_HOST_NETWORK: host_next.network = cfg_data;
                hdlc_rx_pkg::CFG_HOST_ADDRESS: host_next.address = cfg_data;
                default:                       host_next = host_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg <= '0;
        end
        else
        begin
            host_reg <= host_next;
        end
    end

    hdlc_rx_front u_front (
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .wire_byte  (wire_byte),
        .burst_end  (burst_end),
        .q_stat     (q_stat),
        .push       (push),
        .push_token (push_token)
    );

    hdlc_rx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .pop_token  (pop_token),
        .q_stat     (q_stat)
    );

    hdlc_rx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .host      (host_reg),
        .q_stat    (q_stat),
        .tok       (pop_token),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Unpack the result
    assign kind           = res.kind;
    assign data_byte      = res.data_byte;
    assign status         = res.status;
    assign origin_network = res.origin_network;
    assign origin_address = res.origin_address;
    assign frame_type     = res.frame_type;
    assign payload_size   = res.payload_size;

    assign status_ok = (res.status == hdlc_rx_pkg::ST_OK);

    // Checks
    `HDLC_ASSERT_IMPL(a_pop_needs_token, pop, q_stat.valid, "token popped from empty queue")
    `HDLC_ASSERT_IMPL(a_status_no_data, res_valid && kind, data_byte == 8'h00, "status with data")
    `HDLC_ASSERT_IMPL(a_payload_no_status, res_valid && !kind, status_ok, "payload with status")
    `HDLC_ASSERT_NEXT(a_full_holds_wire, q_stat.full && !pop, rx_stall, "wire not held when full")

endmodule
